// ----- hdl/mbde_pkg.sv -----
// Shared types and constants for the multi-button debounce and event unit.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package mbde_pkg;

  localparam int TIME_W  = 32;
  localparam int DEB_W   = 16;
  localparam int FIELD_W = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd50;
  localparam logic [TIME_W-1:0] HOLD_RESET     = 32'd1000;

  // Register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [FIELD_W-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pressed_flags;
    logic [FIELD_W-1:0] released_flags;
    logic [FIELD_W-1:0] held_flags;
    logic [FIELD_W-1:0] debounced_levels;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] hold_ms;
    logic [DEB_W-1:0]  settle_ms;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic released;
    logic held;
    logic level;
  } lane_res_t;

endpackage

// ----- hdl/multi_button_debounce_events_unit.sv -----
// Top level of the multi-button debounce and event unit, with its register port.
// Depends on mbde_pkg, mbde_lane and mbde_merge.
//
// Each input transfer is one sampling tick: a wrapping millisecond timestamp
// and the raw levels of the active-low buttons (1 released, 0 pressed). One
// lane per button keeps the last raw level, the time it last changed, the
// debounced level, the press and release pulses and the times of the last
// press and release. A level is accepted once it has been stable for strictly
// more than the settle time; the pulses then show the edge for that tick, or
// clear when there is none, and otherwise keep their value while the pin is
// still bouncing. A button reads as held when it is low, past its press pulse,
// has seen an edge, and has been stable for at least hold_ms. All time
// differences wrap at 32 bits. The unit takes one tick every clock cycle
// while the result side keeps up: every lane does its whole update in the
// cycle of the transfer, and the merged result is registered, so it is
// offered in the cycle after the tick is taken. The output register lets a
// new tick in only while it is empty or while its result is being taken,
// so throughput stays at one per cycle as long as the result side keeps up.
// Registers: settle_ms at byte address 0 (16 bit, reset 50), hold_ms at 4
// (32 bit, reset 1000); write only while no tick is in flight. Lanes beyond
// the fourth see a low pin and do not show in the result.
module multi_button_debounce_events_unit #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mbde_pkg::in_item_t            in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output mbde_pkg::out_item_t           out_data,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbde_pkg::ADDR_W-1:0]   paddr,
  input  logic [mbde_pkg::DATA_W-1:0]   pwdata,
  output logic [mbde_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  mbde_pkg::cfg_t                        cfg_r, cfg_nxt;
  logic                                  cfg_wr;
  logic                                  cfg_sel;
  logic                                  take;
  mbde_pkg::lane_res_t [NUM_BUTTONS-1:0] lane_res;

  // ---------------------------------------------------------------------
  // Register port: zero wait states, register picked by paddr[2]
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        mbde_pkg::REG_DEBOUNCE: cfg_nxt.settle_ms = pwdata[mbde_pkg::DEB_W-1:0];
        mbde_pkg::REG_HOLD:     cfg_nxt.hold_ms   = pwdata[mbde_pkg::TIME_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      mbde_pkg::REG_DEBOUNCE:
        prdata = {{(mbde_pkg::DATA_W-mbde_pkg::DEB_W){1'b0}}, cfg_r.settle_ms};
      mbde_pkg::REG_HOLD:
        prdata = cfg_r.hold_ms;
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms <= mbde_pkg::DEBOUNCE_RESET;
      cfg_r.hold_ms   <= mbde_pkg::HOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Button lanes: advance every lane on each accepted tick
  // ---------------------------------------------------------------------
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic pin;
    if (b < mbde_pkg::FIELD_W) begin : g_pin
      assign pin = in_data.pin_levels[b];
    end else begin : g_low
      // no pin bit for this button: it reads low
      assign pin = 1'b0;
    end

    mbde_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (take),
      .pin    (pin),
      .now_ms (in_data.now_ms),
      .cfg    (cfg_r),
      .res    (lane_res[b])
    );
  end

  // ---------------------------------------------------------------------
  // Merge lane results and hold them for the result transfer
  // ---------------------------------------------------------------------
  mbde_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .take      (take),
    .lane_res  (lane_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/mbde_lane.sv -----
// One button lane: debounce state, edge pulses, edge times and hold test.
// Depends on mbde_pkg.
module mbde_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              pin,
  input  logic [mbde_pkg::TIME_W-1:0]       now_ms,
  input  mbde_pkg::cfg_t                    cfg,
  output mbde_pkg::lane_res_t               res
);

  logic                        flicker_r, flicker_nxt;
  logic                        stable_r, stable_nxt;
  logic                        press_pulse_r, press_pulse_nxt;
  logic                        release_pulse_r, release_pulse_nxt;
  logic [mbde_pkg::TIME_W-1:0] change_time_r, change_time_nxt;
  logic [mbde_pkg::TIME_W-1:0] press_time_r, press_time_nxt;
  logic [mbde_pkg::TIME_W-1:0] release_time_r, release_time_nxt;
  logic [mbde_pkg::TIME_W-1:0] age;
  logic                        settled;
  logic                        held;

  always_comb begin
    flicker_nxt       = pin;
    change_time_nxt   = (pin != flicker_r) ? now_ms : change_time_r;
    age               = now_ms - change_time_nxt;
    settled           = age > {{(mbde_pkg::TIME_W-mbde_pkg::DEB_W){1'b0}}, cfg.settle_ms};
    stable_nxt        = settled ? pin : stable_r;
    press_pulse_nxt   = press_pulse_r;
    release_pulse_nxt = release_pulse_r;
    press_time_nxt    = press_time_r;
    release_time_nxt  = release_time_r;
    if (settled) begin
      priority if (!pin && stable_r) begin
        press_pulse_nxt = 1'b1;
        press_time_nxt  = now_ms;
      end else if (pin && !stable_r) begin
        release_pulse_nxt = 1'b1;
        release_time_nxt  = now_ms;
      end else begin
        press_pulse_nxt   = 1'b0;
        release_pulse_nxt = 1'b0;
      end
    end
    // held: low, past the press pulse, an edge seen, and stable long enough
    held = (press_time_nxt != release_time_nxt) && !press_pulse_nxt && !pin
           && (age >= cfg.hold_ms);
    res.pressed  = press_pulse_nxt;
    res.released = release_pulse_nxt;
    res.held     = held;
    res.level    = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flicker_r       <= 1'b1;
      stable_r        <= 1'b1;
      press_pulse_r   <= 1'b0;
      release_pulse_r <= 1'b0;
      change_time_r   <= '0;
      press_time_r    <= '0;
      release_time_r  <= '0;
    end else if (en) begin
      flicker_r       <= flicker_nxt;
      stable_r        <= stable_nxt;
      press_pulse_r   <= press_pulse_nxt;
      release_pulse_r <= release_pulse_nxt;
      change_time_r   <= change_time_nxt;
      press_time_r    <= press_time_nxt;
      release_time_r  <= release_time_nxt;
    end
  end

endmodule

// ----- hdl/mbde_merge.sv -----
// Merge stage: packs lane results into one result item and holds it in the
// output register until transferred. Depends on mbde_pkg.
module mbde_merge #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output logic                                  take,
  input  mbde_pkg::lane_res_t [NUM_BUTTONS-1:0] lane_res,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mbde_pkg::out_item_t                   out_data
);

  logic                out_valid_r, out_valid_nxt;
  mbde_pkg::out_item_t out_data_r, out_data_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // Only the first FIELD_W lanes are visible; missing lanes read zero
  for (genvar i = 0; i < mbde_pkg::FIELD_W; i++) begin : g_pack
    if (i < NUM_BUTTONS) begin : g_lane
      assign out_data_nxt.pressed_flags[i]    = lane_res[i].pressed;
      assign out_data_nxt.released_flags[i]   = lane_res[i].released;
      assign out_data_nxt.held_flags[i]       = lane_res[i].held;
      assign out_data_nxt.debounced_levels[i] = lane_res[i].level;
    end else begin : g_none
      assign out_data_nxt.pressed_flags[i]    = 1'b0;
      assign out_data_nxt.released_flags[i]   = 1'b0;
      assign out_data_nxt.held_flags[i]       = 1'b0;
      assign out_data_nxt.debounced_levels[i] = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
